// ===== sv/itemset_support_counter_assert.svh =====
// assertion macros for the itemset support counter
// used by the top level only; expects a signal named clk and rst in scope
`ifndef ITEMSET_SUPPORT_COUNTER_ASSERT_SVH
`define ITEMSET_SUPPORT_COUNTER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define ISC_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("itemset support counter check failed");

// condition holds in the cycle after the trigger
`define ISC_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("itemset support counter check failed");

`endif

// ===== sv/isc_pkg.sv =====
// shared types, codes and sizes for the itemset support counter
// no dependencies; used by every other file of the block but the assert header
package isc_pkg;

  localparam int ITEM_COUNT        = 40;
  localparam int TRANSACTION_DEPTH = 1024;
  localparam int QUEUE_DEPTH       = 2;

  localparam int MASK_W   = 40;
  localparam int ITEM_W   = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 11;
  localparam int ADDR_W   = $clog2(TRANSACTION_DEPTH);
  localparam int BIT_W    = $clog2(ITEM_COUNT);
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_ITEM = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_BAD_ITEM,
    OP_CLOSE,
    OP_QUERY
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } back_state_t;

  // one classified request as it sits in the queue
  typedef struct packed {
    op_t               op;
    logic [BIT_W-1:0]  bit_idx;
    logic [MASK_W-1:0] rule;
    logic [MASK_W-1:0] ante;
  } entry_t;

endpackage

// ===== sv/isc_if.sv =====
// request and result channel interfaces of the itemset support counter
// depends on isc_pkg
interface isc_req_if;
  logic                           valid;
  logic                           ready;
  logic [isc_pkg::CMD_W-1:0]      command;
  logic [isc_pkg::ITEM_W-1:0]     item_id;
  logic [isc_pkg::MASK_W-1:0]     rule_items;
  logic [isc_pkg::MASK_W-1:0]     antecedent_items;

  modport source (output valid, command, item_id, rule_items, antecedent_items,
                  input ready);
  modport sink (input valid, command, item_id, rule_items, antecedent_items,
                output ready);
endinterface

interface isc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [isc_pkg::STATUS_W-1:0]  status;
  logic [isc_pkg::CNT_W-1:0]     rule_count;
  logic [isc_pkg::CNT_W-1:0]     antecedent_count;
  logic [isc_pkg::CNT_W-1:0]     stored_count;

  modport source (output valid, status, rule_count, antecedent_count, stored_count,
                  input ready);
  modport sink (input valid, status, rule_count, antecedent_count, stored_count,
                output ready);
endinterface

// ===== sv/isc_front.sv =====
// front end: takes requests and classifies them into queue entries
// depends on isc_pkg and isc_req_if
module isc_front (
  isc_req_if.sink                req,
  output logic                   push_valid,
  output isc_pkg::entry_t        push_data,
  input  logic                   push_ready
);
  import isc_pkg::*;

  logic item_ok;

  // item must lie in 1..ITEM_COUNT
  assign item_ok = (req.item_id != '0) && (req.item_id <= ITEM_W'(ITEM_COUNT));

  // decode the command into an operation
  always_comb begin
    push_data.bit_idx = BIT_W'(req.item_id - ITEM_W'(1));
    push_data.rule    = req.rule_items;
    push_data.ante    = req.antecedent_items;
    case (req.command)
      CMD_ADD:   push_data.op = item_ok ? OP_ADD : OP_BAD_ITEM;
      CMD_CLOSE: push_data.op = OP_CLOSE;
      CMD_QUERY: push_data.op = OP_QUERY;
      default:   push_data.op = OP_NOP;
    endcase
  end

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

endmodule

// ===== sv/isc_fifo.sv =====
// short queue of classified requests between front and back
// depends on isc_pkg
module isc_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  isc_pkg::entry_t  push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output isc_pkg::entry_t  pop_data,
  input  logic             pop_ready
);
  import isc_pkg::*;

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== sv/isc_back.sv =====
// back end: open transaction, transaction store, support scan, result register
// depends on isc_pkg and isc_rsp_if
module isc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  input  isc_pkg::entry_t  entry,
  output logic             entry_ready,
  isc_rsp_if.source        rsp
);
  import isc_pkg::*;

  logic [MASK_W-1:0]   mem [TRANSACTION_DEPTH];
  logic [MASK_W-1:0]   rd_data;
  back_state_t         state;
  back_state_t         state_next;
  logic [MASK_W-1:0]   open_trans;
  logic [CNT_W-1:0]    filled;
  logic [CNT_W-1:0]    rd_idx;
  logic                pend;
  logic [MASK_W-1:0]   cur_rule;
  logic [MASK_W-1:0]   cur_ante;
  logic [CNT_W-1:0]    rule_cnt;
  logic [CNT_W-1:0]    ante_cnt;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [CNT_W-1:0]    out_rule;
  logic [CNT_W-1:0]    out_ante;
  logic [CNT_W-1:0]    out_stored;
  logic                take;
  logic                has_room;
  logic                mem_we;
  logic                issue;
  logic                done;
  logic                rule_hit;
  logic                ante_hit;
  logic [CNT_W-1:0]    empty_left;

  assign has_room   = (filled < CNT_W'(TRANSACTION_DEPTH));
  assign empty_left = CNT_W'(TRANSACTION_DEPTH) - filled;
  assign rule_hit   = ((rd_data & cur_rule) == cur_rule);
  assign ante_hit   = ((rd_data & cur_ante) == cur_ante);
  assign issue      = (state == ST_SCAN) && (rd_idx < filled);
  assign done       = (state == ST_SCAN) && !issue && !pend;
  assign mem_we     = take && (entry.op == OP_CLOSE) && has_room;

  // next state and request pop
  always_comb begin
    entry_ready = 1'b0;
    state_next  = state;
    take        = 1'b0;
    case (state)
      ST_IDLE: begin
        entry_ready = !out_valid || rsp.ready;
        take        = entry_valid && entry_ready;
        if (take && (entry.op == OP_QUERY)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (done) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // transaction store, read one word a cycle during a scan
  always_ff @(posedge clk) begin
    if (mem_we) mem[filled[ADDR_W-1:0]] <= open_trans;
    if (issue)  rd_data <= mem[rd_idx[ADDR_W-1:0]];
  end

  // control state, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      filled     <= '0;
      open_trans <= '0;
      pend       <= 1'b0;
      rd_idx     <= '0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      pend <= issue;
      if (issue) rd_idx <= rd_idx + CNT_W'(1);
      if (pend) begin
        rule_cnt <= rule_cnt + CNT_W'(rule_hit);
        ante_cnt <= ante_cnt + CNT_W'(ante_hit);
      end

      // commands completed when taken, and query start
      if (take) begin
        out_status <= STATUS_OK;
        out_rule   <= '0;
        out_ante   <= '0;
        out_stored <= filled;
        case (entry.op)
          OP_ADD: begin
            open_trans <= open_trans | (MASK_W'(1) << entry.bit_idx);
            out_valid  <= 1'b1;
          end
          OP_BAD_ITEM: begin
            out_status <= STATUS_BAD_ITEM;
            out_valid  <= 1'b1;
          end
          OP_CLOSE: begin
            open_trans <= '0;
            out_valid  <= 1'b1;
            if (has_room) begin
              filled     <= filled + CNT_W'(1);
              out_stored <= filled + CNT_W'(1);
            end else begin
              out_status <= STATUS_FULL;
            end
          end
          OP_QUERY: begin
            // entries never loaded are empty and match only an empty mask
            cur_rule <= entry.rule;
            cur_ante <= entry.ante;
            rule_cnt <= (entry.rule == '0) ? empty_left : '0;
            ante_cnt <= (entry.ante == '0) ? empty_left : '0;
            rd_idx   <= '0;
          end
          default: out_valid <= 1'b1;
        endcase
      end

      // scan finished, publish counts
      if (done) begin
        out_valid  <= 1'b1;
        out_status <= STATUS_OK;
        out_rule   <= rule_cnt;
        out_ante   <= ante_cnt;
        out_stored <= filled;
      end
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.rule_count       = out_rule;
  assign rsp.antecedent_count = out_ante;
  assign rsp.stored_count     = out_stored;

endmodule

// ===== sv/itemset_support_counter.sv =====
// Itemset support counter. Requests add an item to the open transaction, close
// it into the next store entry if there is room, or query support for a rule and
// antecedent mask; every request gives exactly one result. Requests enter a
// two-entry queue at up to one per cycle while the queue has room; the back end
// takes a new request only when idle and its result register is free or being
// read, and a query scans the single-port transaction store one word per cycle.
// Entries beyond the fill count are known empty and are counted without reading.
// Depends on isc_pkg, isc_if, isc_front, isc_fifo, isc_back and the assert header.
module itemset_support_counter (
  input  logic       clk,
  input  logic       rst,
  isc_req_if.sink    req,
  isc_rsp_if.source  rsp
);
  import isc_pkg::*;
  `include "itemset_support_counter_assert.svh"

  logic   push_valid;
  logic   push_ready;
  entry_t push_data;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_data;

  isc_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  isc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  isc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_valid (pop_valid),
    .entry       (pop_data),
    .entry_ready (pop_ready),
    .rsp         (rsp)
  );

  // checks on results and on the scan
  `ISC_ASSERT_SAME(a_stored_bound, rsp.valid, rsp.stored_count <= CNT_W'(TRANSACTION_DEPTH))
  `ISC_ASSERT_SAME(a_full_means_full, rsp.valid && (rsp.status == STATUS_FULL), rsp.stored_count == CNT_W'(TRANSACTION_DEPTH))
  `ISC_ASSERT_SAME(a_err_no_counts, rsp.valid && (rsp.status != STATUS_OK), (rsp.rule_count == '0) && (rsp.antecedent_count == '0))
  `ISC_ASSERT_NEXT(a_scan_blocks_pop, (u_back.state == ST_SCAN) && !u_back.done, !(pop_valid && pop_ready) || (u_back.state == ST_IDLE))

endmodule
